// ===== hdl/fde_pkg.sv =====
`default_nettype none

package fde_pkg;

  // Knob format: unsigned Q1.16 held in 17-bit registers
  localparam int unsigned KnobFracBits = 16;
  localparam int unsigned KnobWidth    = 17;
  localparam logic [KnobWidth-1:0] KnobOne = KnobWidth'(1 << KnobFracBits);

  // Internal samples are Q8.23
  localparam int unsigned IntFrac = 23;

  // Multiplier constants, Q0.20; FuzzSpan is a plain integer
  localparam int unsigned C0p1   = 104858;
  localparam int unsigned C0p15  = 157286;
  localparam int unsigned C0p995 = 1043333;
  localparam int unsigned C0p2   = 209715;
  localparam int unsigned C0p79  = 828375;
  localparam int unsigned C0p8   = 838861;
  localparam int unsigned One20  = 1 << 20;
  localparam int unsigned FuzzSpan = 199;

  // Thresholds, Q.23
  localparam logic signed [31:0] Th0p5 = 32'sd4194304;
  localparam logic signed [31:0] Th0p6 = 32'sd5033165;
  localparam logic signed [31:0] Th0p4 = 32'sd3355443;

  // Clip curve codes
  localparam logic [1:0] ClipVintage = 2'd0;
  localparam logic [1:0] ClipModern  = 2'd1;
  localparam logic [1:0] ClipOctave  = 2'd2;

  // Register indexes on the configuration port
  localparam logic [2:0] RegFuzz  = 3'd0;
  localparam logic [2:0] RegTone  = 3'd1;
  localparam logic [2:0] RegGate  = 3'd2;
  localparam logic [2:0] RegLevel = 3'd3;
  localparam logic [2:0] RegMix   = 3'd4;
  localparam logic [2:0] RegClip  = 3'd5;

  // Register reset values
  localparam logic [KnobWidth-1:0] FuzzReset  = 17'd45875;
  localparam logic [KnobWidth-1:0] ToneReset  = 17'd32768;
  localparam logic [KnobWidth-1:0] GateReset  = 17'd0;
  localparam logic [KnobWidth-1:0] LevelReset = 17'd45875;
  localparam logic [KnobWidth-1:0] MixReset   = 17'd65536;
  localparam logic [1:0]           ClipReset  = ClipVintage;

  // Default sample width
  localparam int unsigned SampleWidthDefault = 24;

  // Limit a knob to 1.0
  function automatic logic [KnobWidth-1:0] knob_sat(input logic [KnobWidth-1:0] k);
    return (k > KnobOne) ? KnobOne : k;
  endfunction

  // Round half up, then arithmetic shift right (s >= 1)
  function automatic logic signed [57:0] rshr(input logic signed [57:0] v,
                                              input int unsigned s);
    logic signed [57:0] half;
    half = 58'sd1 <<< (s - 1);
    return (v + half) >>> s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fuzz_distortion_audio_effect_unit.sv =====
// Fuzz distortion audio effect.
// Input samples arrive on the s_axis stream (tdata = sample_in, signed Q1.x),
// processed samples leave on the m_axis stream (tdata = sample_out, saturated).
// Knobs are written over the APB port: fuzz, tone, gate, level, mix at byte
// addresses 0x00..0x10 (Q1.16, 65536 = 1.0), clip character at 0x14. Write
// them only while no sample is in flight.
// Each sample runs through gate, pre-gain, clip curve, difference stage,
// one-pole lowpass, dry/wet blend and level on one shared 32x25 multiplier
// under a 15-step sequencer: the sample is taken while idle, the steps run
// in order and the last step loads the result into the output register;
// only then can the next sample be taken. s_axis_tready is high
// only while the sequencer is idle.
// The output register lets a new sample be taken while a result still waits;
// if m_axis_tready stays low, the sequencer holds its last step until the
// output register frees up.
// Reset clears the difference and lowpass history to zero and loads the
// knob defaults; no clearing pass is needed.
`default_nettype none

module fuzz_distortion_audio_effect_unit
  import fde_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tdata: [SAMPLE_WIDTH-1:0] sample_in, rest zero fill
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: [SAMPLE_WIDTH-1:0] sample_out, rest zero fill
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [4:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int unsigned TdataWidth = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned Sw1        = SAMPLE_WIDTH - 1;
  // Shift between Q1.(SW-1) and the Q.23 internal format
  localparam int unsigned DnShift  = (Sw1 > IntFrac) ? Sw1 - IntFrac : 0;
  localparam int unsigned UpShift  = (Sw1 < IntFrac) ? IntFrac - Sw1 : 0;
  localparam int unsigned HalfSh   = (DnShift > 0) ? DnShift - 1 : 0;
  localparam logic signed [40:0] RndHalf = (DnShift > 0) ? (41'sd1 <<< HalfSh) : 41'sd0;
  localparam logic signed [40:0] OutMax  = (41'sd1 <<< Sw1) - 41'sd1;
  localparam logic signed [40:0] OutMin  = -(41'sd1 <<< Sw1);

  // Sequencer states and steps
  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StRun  = 1'b1;

  localparam logic [3:0] SqGate   = 4'd0;   // issue gate*0.1
  localparam logic [3:0] SqFuzz   = 4'd1;   // take threshold, issue fuzz*199
  localparam logic [3:0] SqTone   = 4'd2;   // take gain, gate x, issue tone*0.79
  localparam logic [3:0] SqLevel  = 4'd3;   // take alpha, issue level*0.8
  localparam logic [3:0] SqGain   = 4'd4;   // take level, issue x*gain
  localparam logic [3:0] SqLpHist = 4'd5;   // take amp, issue (1-alpha)*lp_prev
  localparam logic [3:0] SqClip   = 4'd6;   // hold lowpass term, issue knee product
  localparam logic [3:0] SqClipEnd= 4'd7;   // take clipped value
  localparam logic [3:0] SqDiff   = 4'd8;   // form y, issue c*0.995
  localparam logic [3:0] SqLpIn   = 4'd9;   // update history, issue alpha*y
  localparam logic [3:0] SqDry    = 4'd10;  // take lowpass, issue dry term
  localparam logic [3:0] SqWet    = 4'd11;  // hold dry term, issue lp*mix
  localparam logic [3:0] SqMix    = 4'd12;  // take blend
  localparam logic [3:0] SqOut    = 4'd13;  // issue wet*level
  localparam logic [3:0] SqLast   = 4'd14;  // rescale, saturate, load output

  // Configuration registers
  logic [KnobWidth-1:0] fuzz_q, tone_q, gate_q, level_q, mix_q;
  logic [1:0]           clip_q;

  // Sequencer
  logic [0:0] state_q, state_d;
  logic [3:0] step_q, step_d;

  // Datapath registers
  logic signed [24:0] x_q;
  logic [19:0]        thr_q;
  logic [23:0]        gain_q;
  logic [19:0]        a20_q;
  logic [19:0]        lvl_q;
  logic signed [31:0] a_q, c_q, y_q, wet_q;
  logic signed [31:0] dh_q, lph_q;
  logic signed [56:0] p_q, acc_q;

  // Output register
  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] out_data_q;

  // Combinational datapath
  logic signed [31:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [56:0] prod;
  logic signed [57:0] p_ext, sum_ext;
  logic signed [57:0] r13, r16, r20, rs16, rs20;
  logic signed [32:0] s_ext;
  logic signed [32:0] x_in;
  logic [24:0]        x_mag;
  logic               gate_hit;
  logic signed [31:0] clip_val;
  logic signed [33:0] oct_a, oct_r, oct_sum;
  logic signed [32:0] diff33;
  logic signed [31:0] y_sat;
  logic signed [40:0] o_ext, o_scl, o_sat;
  logic               s_xfer, out_load;
  logic               cfg_wr;

  // APB writes and reads
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fuzz_q  <= FuzzReset;
      tone_q  <= ToneReset;
      gate_q  <= GateReset;
      level_q <= LevelReset;
      mix_q   <= MixReset;
      clip_q  <= ClipReset;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        RegFuzz:  fuzz_q  <= pwdata[KnobWidth-1:0];
        RegTone:  tone_q  <= pwdata[KnobWidth-1:0];
        RegGate:  gate_q  <= pwdata[KnobWidth-1:0];
        RegLevel: level_q <= pwdata[KnobWidth-1:0];
        RegMix:   mix_q   <= pwdata[KnobWidth-1:0];
        RegClip:  clip_q  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegFuzz:  prdata = 32'(fuzz_q);
      RegTone:  prdata = 32'(tone_q);
      RegGate:  prdata = 32'(gate_q);
      RegLevel: prdata = 32'(level_q);
      RegMix:   prdata = 32'(mix_q);
      RegClip:  prdata = 32'(clip_q);
      default:  prdata = 32'd0;
    endcase
  end

  // Handshakes
  assign s_axis_tready = (state_q == StIdle);
  assign s_xfer        = s_axis_tvalid & s_axis_tready;
  assign out_load      = (state_q == StRun) && (step_q == SqLast) &&
                         (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TdataWidth'(out_data_q);

  // Bring the input to Q.23
  assign s_ext = 33'(signed'(s_axis_tdata[SAMPLE_WIDTH-1:0]));
  assign x_in  = 33'(((41'(s_ext) + RndHalf) >>> DnShift) <<< UpShift);

  // Shared multiplier operands
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 25'sd0;
    unique case (step_q)
      SqGate: begin
        mul_a = {15'd0, knob_sat(gate_q)};
        mul_b = 25'(C0p1);
      end
      SqFuzz: begin
        mul_a = {15'd0, knob_sat(fuzz_q)};
        mul_b = 25'(FuzzSpan);
      end
      SqTone: begin
        mul_a = {15'd0, knob_sat(tone_q)};
        mul_b = 25'(C0p79);
      end
      SqLevel: begin
        mul_a = {15'd0, knob_sat(level_q)};
        mul_b = 25'(C0p8);
      end
      SqGain: begin
        mul_a = 32'(x_q);
        mul_b = {1'b0, gain_q};
      end
      SqLpHist: begin
        mul_a = lph_q;
        mul_b = 25'(One20) - {5'd0, a20_q};
      end
      SqClip: begin
        if (a_q > Th0p5) begin
          mul_a = a_q - Th0p5;
          mul_b = 25'(C0p1);
        end else begin
          mul_a = a_q + Th0p6;
          mul_b = 25'(C0p15);
        end
      end
      SqDiff: begin
        mul_a = c_q;
        mul_b = 25'(C0p995);
      end
      SqLpIn: begin
        mul_a = y_q;
        mul_b = {5'd0, a20_q};
      end
      SqDry: begin
        mul_a = 32'(x_q);
        mul_b = 25'(KnobOne) - {8'd0, knob_sat(mix_q)};
      end
      SqWet: begin
        mul_a = lph_q;
        mul_b = {8'd0, knob_sat(mix_q)};
      end
      SqOut: begin
        mul_a = wet_q;
        mul_b = {5'd0, lvl_q};
      end
      default: ;
    endcase
  end

  assign prod = 57'(mul_a) * 57'(mul_b);

  // Rounded views of the product and of product plus accumulator
  assign p_ext   = {p_q[56], p_q};
  assign sum_ext = p_ext + {acc_q[56], acc_q};
  assign r13     = rshr(p_ext, KnobFracBits + 20 - IntFrac);
  assign r16     = rshr(p_ext, KnobFracBits);
  assign r20     = rshr(p_ext, 20);
  assign rs16    = rshr(sum_ext, KnobFracBits);
  assign rs20    = rshr(sum_ext, 20);

  // Noise gate compare
  assign x_mag    = x_q[24] ? 25'(-x_q) : 25'(x_q);
  assign gate_hit = {1'b0, x_mag} < {6'd0, thr_q};

  // Clip curves
  assign oct_a   = 34'(a_q);
  always_comb begin
    oct_r = oct_a[33] ? -oct_a : oct_a;
    if (oct_r > 34'(Th0p5)) oct_r = 34'(Th0p5);
    if (oct_a <= 34'sd0) oct_r = -oct_r;
  end
  assign oct_sum = (oct_r + oct_a + 34'sd1) >>> 1;

  always_comb begin
    case (clip_q)
      ClipVintage: begin
        if (a_q > Th0p5)       clip_val = Th0p5 + r20[31:0];
        else if (a_q < -Th0p6) clip_val = -Th0p6 + r20[31:0];
        else                   clip_val = a_q;
      end
      ClipModern: begin
        if (a_q > Th0p4)       clip_val = Th0p4;
        else if (a_q < -Th0p4) clip_val = -Th0p4;
        else                   clip_val = a_q;
      end
      ClipOctave: clip_val = oct_sum[31:0];
      default:    clip_val = oct_sum[31:0];
    endcase
  end

  // Difference stage with saturation to 32 bits
  assign diff33 = 33'(c_q) - 33'(dh_q);
  always_comb begin
    if (diff33[32] != diff33[31]) y_sat = diff33[32] ? 32'sh80000000 : 32'sh7fffffff;
    else                          y_sat = diff33[31:0];
  end

  // Final level, rescale to the sample format and saturate
  assign o_ext = r20[40:0];
  assign o_scl = ((o_ext <<< DnShift) + ((UpShift > 0) ? (41'sd1 <<< ((UpShift > 0) ?
                 UpShift - 1 : 0)) : 41'sd0)) >>> UpShift;
  always_comb begin
    if (o_scl > OutMax)      o_sat = OutMax;
    else if (o_scl < OutMin) o_sat = OutMin;
    else                     o_sat = o_scl;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        step_d = SqGate;
        if (s_xfer) state_d = StRun;
      end
      StRun: begin
        if (step_q == SqLast) begin
          if (out_load) begin
            state_d = StIdle;
            step_d  = SqGate;
          end
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      default: begin
        state_d = StIdle;
        step_d  = SqGate;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= SqGate;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Filter history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dh_q  <= 32'sd0;
      lph_q <= 32'sd0;
    end else if (state_q == StRun) begin
      if (step_q == SqLpIn) dh_q  <= r20[31:0];
      if (step_q == SqDry)  lph_q <= rs20[31:0];
    end
  end

  // Datapath registers, one update per step
  always_ff @(posedge clk_i) begin
    if (s_xfer) x_q <= x_in[24:0];
    if (state_q == StRun) begin
      if (step_q != SqLast) p_q <= prod;
      case (step_q)
        SqFuzz:    thr_q  <= r13[19:0];
        SqTone: begin
          gain_q <= 24'(KnobOne) + p_q[23:0];
          if (gate_hit) x_q <= 25'sd0;
        end
        SqLevel:   a20_q  <= 20'(C0p2) + r16[19:0];
        SqGain:    lvl_q  <= r16[19:0];
        SqLpHist:  a_q    <= r16[31:0];
        SqClip:    acc_q  <= p_q;
        SqClipEnd: c_q    <= clip_val;
        SqDiff:    y_q    <= y_sat;
        SqWet:     acc_q  <= p_q;
        SqMix:     wet_q  <= rs16[31:0];
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= o_sat[SAMPLE_WIDTH-1:0];
  end

  // Checks
  a_take_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> (state_q == StRun) && (step_q == SqGate))
    else $error("accepted sample did not start the sequencer");

  a_idle_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (step_q == SqGate))
    else $error("step counter moved while idle");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StRun && step_q == SqLast))
    else $error("result appeared outside the last step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready && (state_q == StRun) && (step_q == SqLast)
    |=> (state_q == StRun) && $stable(out_data_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== tb/sv/fde_sample_checker.sv =====
`timescale 1ns / 100ps

module fde_sample_checker
  import fde_pkg::*;
#(
  parameter int unsigned SampleBits = SampleWidthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tdata: [SampleBits-1:0] sample_in
  input  wire logic [((SampleBits+7)/8)*8-1:0]   s_axis_tdata_i,
  input  wire logic                              s_axis_tvalid_i,
  input  wire logic                              s_axis_tready_i,
  // tdata: [SampleBits-1:0] sample_out
  input  wire logic [((SampleBits+7)/8)*8-1:0]   m_axis_tdata_i,
  input  wire logic                              m_axis_tvalid_i,
  input  wire logic                              m_axis_tready_i,
  input  wire logic                              psel_i,
  input  wire logic                              penable_i,
  input  wire logic                              pwrite_i,
  input  wire logic [4:0]                        paddr_i,
  input  wire logic [31:0]                       pwdata_i,
  input  wire logic [31:0]                       prdata_i,
  input  wire logic                              pready_i,
  output int                                     mismatch_count_o,
  output int                                     samples_in_flight_o
);

  // Arithmetic constants as signed 64-bit values
  localparam longint OneK      = longint'(1) << KnobFracBits;
  localparam longint OneQ20    = One20;
  localparam longint GateStep  = C0p1;
  localparam longint KneeUp    = C0p1;
  localparam longint KneeDown  = C0p15;
  localparam longint Leak      = C0p995;
  localparam longint AlphaBase = C0p2;
  localparam longint AlphaSpan = C0p79;
  localparam longint LevelTrim = C0p8;
  localparam longint GainSpan  = FuzzSpan;
  localparam longint Knee      = Th0p5;
  localparam longint Floor     = Th0p6;
  localparam longint HardRail  = Th0p4;
  localparam longint AccMax    = (longint'(1) << 31) - 1;
  localparam longint SampleMax = (longint'(1) << (SampleBits - 1)) - 1;

  // Knob copies, tracked from the register writes
  logic [KnobWidth-1:0] fuzz_q, tone_q, gate_q, level_q, mix_q;
  logic [1:0]           clip_q;

  // Filter history, Q8.23
  longint diff_hist, lowpass_hist;

  logic [SampleBits-1:0] expected_samples[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  function automatic longint round_shift(input longint v, input int unsigned s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // A knob above 1.0 acts as 1.0
  function automatic longint knob_value(input logic [KnobWidth-1:0] k);
    if (k > KnobOne) return OneK;
    return k;
  endfunction

  function automatic logic [31:0] register_value(input logic [2:0] idx);
    case (idx)
      RegFuzz:  return 32'(fuzz_q);
      RegTone:  return 32'(tone_q);
      RegGate:  return 32'(gate_q);
      RegLevel: return 32'(level_q);
      RegMix:   return 32'(mix_q);
      RegClip:  return 32'(clip_q);
      default:  return '0;
    endcase
  endfunction

  // Run one sample through the effect chain and advance the filter history
  function automatic logic [SampleBits-1:0] predict_fuzz_sample(
      input logic [SampleBits-1:0] raw);
    longint x, thr, mag, gain, amp, c, y, a20, lp, mix, wet, lvl, o;
    x = $signed(raw);

    // bring the sample to the Q.23 internal format
    if (SampleBits - 1 > IntFrac) x = round_shift(x, SampleBits - 1 - IntFrac);
    else x = x <<< (IntFrac - (SampleBits - 1));

    // noise gate
    thr = round_shift(knob_value(gate_q) * GateStep, KnobFracBits + 20 - IntFrac);
    mag = (x < 0) ? -x : x;
    if (mag < thr) x = 0;

    // pre-gain
    gain = OneK + knob_value(fuzz_q) * GainSpan;
    amp  = round_shift(x * gain, KnobFracBits);

    // clip curve; the unused code behaves as octave
    case (clip_q)
      ClipVintage: begin
        if (amp > Knee) c = Knee + round_shift((amp - Knee) * KneeUp, 20);
        else if (amp < -Floor) c = -Floor + round_shift((amp + Floor) * KneeDown, 20);
        else c = amp;
      end
      ClipModern: begin
        c = clamp_to(amp, -HardRail, HardRail);
      end
      default: begin
        mag = (amp < 0) ? -amp : amp;
        if (mag > Knee) mag = Knee;
        if (amp <= 0) mag = -mag;
        c = round_shift(mag + amp, 1);
      end
    endcase

    // difference stage, saturated to the internal range
    y = clamp_to(c - diff_hist, -AccMax - 1, AccMax);
    diff_hist = round_shift(c * Leak, 20);

    // one-pole lowpass
    a20 = AlphaBase + round_shift(knob_value(tone_q) * AlphaSpan, KnobFracBits);
    lp  = round_shift(a20 * y + (OneQ20 - a20) * lowpass_hist, 20);
    lowpass_hist = lp;

    // blend with the gated input, then output level
    mix = knob_value(mix_q);
    wet = round_shift(x * (OneK - mix) + lp * mix, KnobFracBits);
    lvl = round_shift(knob_value(level_q) * LevelTrim, KnobFracBits);
    o   = round_shift(wet * lvl, 20);

    // back to the sample format, then saturate
    if (SampleBits - 1 > IntFrac) o = o <<< (SampleBits - 1 - IntFrac);
    else o = round_shift(o, IntFrac - (SampleBits - 1));
    o   = clamp_to(o, -SampleMax - 1, SampleMax);
    return o[SampleBits-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [SampleBits-1:0] want;
    if (!rst_ni) begin
      fuzz_q  = FuzzReset;
      tone_q  = ToneReset;
      gate_q  = GateReset;
      level_q = LevelReset;
      mix_q   = MixReset;
      clip_q  = ClipReset;
      diff_hist    = 0;
      lowpass_hist = 0;
      expected_samples.delete();
    end else begin
      // compare each output transfer with the oldest prediction
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("sample_out with nothing pending", 32'(m_axis_tdata_i), '0);
        end else begin
          want = expected_samples.pop_front();
          if (m_axis_tdata_i[SampleBits-1:0] !== want)
            report_mismatch("sample_out", 32'(m_axis_tdata_i[SampleBits-1:0]), 32'(want));
        end
      end

      // track knob writes and check reads against the tracked values
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i[4:2])
            RegFuzz:  fuzz_q  = pwdata_i[KnobWidth-1:0];
            RegTone:  tone_q  = pwdata_i[KnobWidth-1:0];
            RegGate:  gate_q  = pwdata_i[KnobWidth-1:0];
            RegLevel: level_q = pwdata_i[KnobWidth-1:0];
            RegMix:   mix_q   = pwdata_i[KnobWidth-1:0];
            RegClip:  clip_q  = pwdata_i[1:0];
            default: ;
          endcase
        end else if (prdata_i !== register_value(paddr_i[4:2])) begin
          report_mismatch("register read", prdata_i, register_value(paddr_i[4:2]));
        end
      end

      // predict each input transfer
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_samples.push_back(predict_fuzz_sample(s_axis_tdata_i[SampleBits-1:0]));
    end
    samples_in_flight_o = expected_samples.size();
  end

endmodule

// ===== tb/sv/fuzz_distortion_audio_effect_unit_test.sv =====
`timescale 1ns / 100ps

module fuzz_distortion_audio_effect_unit_test;
  import fde_pkg::*;

  localparam int unsigned SampleBits    = SampleWidthDefault;
  localparam int unsigned DataBits      = ((SampleBits + 7) / 8) * 8;
  localparam int unsigned CycleLimit    = 1000000;
  localparam int unsigned DrainCycles   = 32;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned ItemsPerPhase = 244;

  // Clip code with no curve of its own, register slots with no register
  localparam logic [1:0] ClipSpare    = 2'd3;
  localparam logic [2:0] RegSpareLow  = 3'd6;
  localparam logic [2:0] RegSpareHigh = 3'd7;

  localparam logic [SampleBits-1:0] FullPos = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic [SampleBits-1:0] FullNeg = {1'b1, {(SampleBits-1){1'b0}}};
  // Gate threshold with the gate knob at 1.0
  localparam int GateEdge = 838864;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic [DataBits-1:0] s_axis_tdata  = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DataBits-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [4:0]          paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;

  int                    mismatch_count;
  int                    samples_in_flight;
  int unsigned           burst_left;
  int unsigned           ready_run;
  int unsigned           cycle_count;
  logic [SampleBits-1:0] saw_value;
  logic [SampleBits-1:0] saw_step;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fuzz_distortion_audio_effect_unit #(
    .SAMPLE_WIDTH(SampleBits)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  fde_sample_checker #(
    .SampleBits(SampleBits)
  ) sample_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s_axis_tdata_i     (s_axis_tdata),
    .s_axis_tvalid_i    (s_axis_tvalid),
    .s_axis_tready_i    (s_axis_tready),
    .m_axis_tdata_i     (m_axis_tdata),
    .m_axis_tvalid_i    (m_axis_tvalid),
    .m_axis_tready_i    (m_axis_tready),
    .psel_i             (psel),
    .penable_i          (penable),
    .pwrite_i           (pwrite),
    .paddr_i            (paddr),
    .pwdata_i           (pwdata),
    .prdata_i           (prdata),
    .pready_i           (pready),
    .mismatch_count_o   (mismatch_count),
    .samples_in_flight_o(samples_in_flight)
  );

  // Output side: alternate long ready stretches, short flickers and stalls
  always @(negedge clk_i) begin
    if (ready_run != 0) begin
      ready_run = ready_run - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          m_axis_tready <= 1'b1;
          ready_run = $urandom_range(20, 200);
        end
        1: begin
          m_axis_tready <= 1'b0;
          ready_run = $urandom_range(1, 40);
        end
        2: begin
          m_axis_tready <= 1'b1;
          ready_run = $urandom_range(0, 4);
        end
        default: begin
          m_axis_tready <= 1'b0;
          ready_run = $urandom_range(0, 2);
        end
      endcase
    end
  end

  // End the run if it hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[fuzz_distortion_audio_effect_unit] ERROR");
    $finish;
  end

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_access(input logic write_en, input logic [2:0] reg_idx,
                            input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_back_all();
    for (int r = RegFuzz; r <= RegClip; r++)
      apb_access(1'b0, 3'(r), '0);
  endtask

  task automatic set_knobs(input logic [KnobWidth-1:0] fuzz, tone, gate, level, mix,
                           input logic [1:0] clip);
    apb_access(1'b1, RegFuzz, 32'(fuzz));
    apb_access(1'b1, RegTone, 32'(tone));
    apb_access(1'b1, RegGate, 32'(gate));
    apb_access(1'b1, RegLevel, 32'(level));
    apb_access(1'b1, RegMix, 32'(mix));
    apb_access(1'b1, RegClip, 32'(clip));
    read_back_all();
  endtask

  // Offer one sample; between bursts hold valid low for a random gap
  task automatic send_sample(input logic [SampleBits-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tdata  <= DataBits'(value);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
  endtask

  // Drop valid and wait until every predicted sample has come out
  task automatic end_phase();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    wait (samples_in_flight == 0);
    @(negedge clk_i);
  endtask

  function automatic logic [KnobWidth-1:0] pick_knob();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return KnobOne;
      2:       return KnobWidth'($urandom_range(KnobOne + 1, (1 << KnobWidth) - 1));
      3:       return KnobWidth'($urandom_range(0, 4096));
      default: return KnobWidth'($urandom_range(0, KnobOne));
    endcase
  endfunction

  initial begin
    logic [SampleBits-1:0] sample;
    int                    small_value;
    burst_left = 0;
    ready_run  = 0;
    saw_value  = '0;
    saw_step   = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset knobs, full-scale corners through the vintage curve
    read_back_all();
    send_sample('0);
    send_sample(FullPos);
    send_sample(FullNeg);
    send_sample('1);
    send_sample(SampleBits'(1));
    send_sample(SampleBits'(1 << (SampleBits - 2)));
    end_phase();

    // hard clip at full drive; alternate rails to stress the difference stage
    set_knobs(KnobOne, '0, '0, KnobOne, KnobOne, ClipModern);
    send_sample(FullPos);
    send_sample(FullNeg);
    send_sample(FullPos);
    send_sample(FullNeg);
    send_sample(SampleBits'(1));
    send_sample('1);
    end_phase();

    // every knob but the gate above 1.0, gate at 1.0, octave curve, samples on both sides of the gate
    set_knobs('1, '1, KnobOne, '1, '1, ClipOctave);
    send_sample(SampleBits'(GateEdge - 1));
    send_sample(SampleBits'(GateEdge));
    send_sample(SampleBits'(-GateEdge));
    send_sample(SampleBits'(-(GateEdge - 1)));
    send_sample(FullPos);
    send_sample(FullNeg);
    end_phase();

    // dry only, no pre-gain, unused clip code
    set_knobs('0, KnobOne, '0, KnobOne, '0, ClipSpare);
    send_sample(FullPos);
    send_sample(FullNeg);
    send_sample(SampleBits'(24'h123456));
    send_sample(SampleBits'(-5));
    end_phase();

    // writes to unused slots must leave every knob alone
    apb_access(1'b1, RegSpareLow, $urandom());
    apb_access(1'b1, RegSpareHigh, $urandom());
    read_back_all();
    send_sample(FullPos);
    send_sample(SampleBits'(24'h654321));
    send_sample(FullNeg);
    end_phase();

    // random knob settings, mixed program material
    for (int phase = 0; phase < RandomPhases; phase++) begin
      set_knobs(pick_knob(), pick_knob(), pick_knob() >> $urandom_range(0, 3),
                pick_knob(), pick_knob(), 2'($urandom_range(ClipVintage, ClipSpare)));
      saw_step = SampleBits'($urandom_range(1, 1 << 18));
      repeat (ItemsPerPhase) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: sample = SampleBits'($urandom());
          4, 5: begin
            small_value = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            sample = SampleBits'(small_value);
          end
          6: begin
            sample = $urandom_range(0, 1) ? FullPos - SampleBits'($urandom_range(0, 15))
                                          : FullNeg + SampleBits'($urandom_range(0, 15));
          end
          default: begin
            saw_value = saw_value + saw_step;
            sample = saw_value;
          end
        endcase
        send_sample(sample);
      end
      end_phase();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[fuzz_distortion_audio_effect_unit] OK");
    end else begin
      $display("[fuzz_distortion_audio_effect_unit] ERROR");
    end
    $finish;
  end

endmodule
